[rtl/arp_res_pkg.sv]
`timescale 1ns / 1ps

package arp_res_pkg;

    // input word modes
    localparam logic [1:0] MODE_PKT   = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // result actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;
    localparam logic [1:0] ACT_HIT     = 2'd3;

    // entry status codes
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_PENDING = 2'd2;

    // arp packet checks
    localparam logic [10:0] MIN_PKT_LEN = 11'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    // register indexes
    localparam logic [1:0] REG_LOCAL_IP        = 2'd0;
    localparam logic [1:0] REG_VALID_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_PENDING_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_MAX_RETRIES     = 2'd3;

    // register reset values
    localparam logic [31:0] RST_LOCAL_IP        = 32'd0;
    localparam logic [15:0] RST_VALID_TIMEOUT   = 16'd5;
    localparam logic [15:0] RST_PENDING_TIMEOUT = 16'd1;
    localparam logic [7:0]  RST_MAX_RETRIES     = 8'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [10:0] pkt_len;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [1:0]  entry_status;
    } t_out_word;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [15:0] valid_timeout;
        logic [15:0] pending_timeout;
        logic [7:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] countdown;
        logic [7:0]  retries;
    } t_entry;

endpackage

[rtl/arp_res_cfg.sv]
`timescale 1ns / 1ps

module arp_res_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output arp_res_pkg::t_cfg   o_cfg
);
    import arp_res_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_ip        <= RST_LOCAL_IP;
            r_cfg.valid_timeout   <= RST_VALID_TIMEOUT;
            r_cfg.pending_timeout <= RST_PENDING_TIMEOUT;
            r_cfg.max_retries     <= RST_MAX_RETRIES;
        end else if (w_wr) begin
            case (w_idx)
                REG_LOCAL_IP:        r_cfg.local_ip        <= pwdata;
                REG_VALID_TIMEOUT:   r_cfg.valid_timeout   <= pwdata[15:0];
                REG_PENDING_TIMEOUT: r_cfg.pending_timeout <= pwdata[15:0];
                REG_MAX_RETRIES:     r_cfg.max_retries     <= pwdata[7:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_LOCAL_IP:        prdata = r_cfg.local_ip;
            REG_VALID_TIMEOUT:   prdata = {16'd0, r_cfg.valid_timeout};
            REG_PENDING_TIMEOUT: prdata = {16'd0, r_cfg.pending_timeout};
            REG_MAX_RETRIES:     prdata = {24'd0, r_cfg.max_retries};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

[rtl/arp_res_eval.sv]
`timescale 1ns / 1ps

module arp_res_eval (
    input  arp_res_pkg::t_in_word  i_word,
    input  arp_res_pkg::t_entry    i_entry,
    input  arp_res_pkg::t_cfg      i_cfg,
    output arp_res_pkg::t_entry    o_entry,
    output arp_res_pkg::t_out_word o_result
);
    import arp_res_pkg::*;

    logic        w_pkt_ok;
    logic        w_expired;
    logic [15:0] w_count_dec;

    // packet acceptance checks
    assign w_pkt_ok = (i_word.pkt_len >= MIN_PKT_LEN)
                   && (i_word.hw_type == HW_ETHERNET)
                   && (i_word.proto_type == PROTO_IPV4)
                   && (i_word.hw_len == HW_ADDR_LEN)
                   && (i_word.proto_len == IP_ADDR_LEN)
                   && ((i_word.opcode == OP_REQUEST) || (i_word.opcode == OP_REPLY))
                   && (i_word.tgt_ip == i_cfg.local_ip);

    // countdown runs out at one or zero, never wraps
    assign w_expired   = (i_entry.countdown <= 16'd1);
    assign w_count_dec = w_expired ? 16'd0 : i_entry.countdown - 16'd1;

    // next entry and result word
    always_comb begin
        o_entry           = i_entry;
        o_result.action   = ACT_NONE;
        o_result.peer_mac = 48'd0;
        o_result.peer_ip  = 32'd0;
        case (i_word.mode)
            MODE_PKT: begin
                if (w_pkt_ok) begin
                    if (i_word.opcode == OP_REQUEST) begin
                        o_result.action   = ACT_REPLY;
                        o_result.peer_mac = i_word.src_mac;
                        o_result.peer_ip  = i_word.src_ip;
                    end
                    o_entry.ip        = i_word.src_ip;
                    o_entry.mac       = i_word.src_mac;
                    o_entry.status    = ST_VALID;
                    o_entry.countdown = i_cfg.valid_timeout;
                    o_entry.retries   = i_cfg.max_retries;
                end
            end
            MODE_TICK: begin
                if (i_entry.status == ST_VALID) begin
                    o_entry.countdown = w_count_dec;
                    if (w_expired) begin
                        o_result.action   = ACT_REQUEST;
                        o_result.peer_ip  = i_entry.ip;
                        o_entry.status    = ST_PENDING;
                        o_entry.countdown = i_cfg.pending_timeout;
                    end
                end else if (i_entry.status == ST_PENDING) begin
                    o_entry.countdown = w_count_dec;
                    if (w_expired) begin
                        if (i_entry.retries == 8'd0) begin
                            o_entry.status = ST_FREE;
                        end else begin
                            o_entry.retries   = i_entry.retries - 8'd1;
                            o_result.action   = ACT_REQUEST;
                            o_result.peer_ip  = i_entry.ip;
                            o_entry.countdown = i_cfg.pending_timeout;
                        end
                    end
                end
            end
            MODE_QUERY: begin
                if ((i_entry.status == ST_VALID) && (i_entry.ip == i_word.query_ip)) begin
                    o_result.action   = ACT_HIT;
                    o_result.peer_mac = i_entry.mac;
                    o_result.peer_ip  = i_entry.ip;
                end else begin
                    o_result.action  = ACT_REQUEST;
                    o_result.peer_ip = i_word.query_ip;
                end
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
        o_result.entry_status = o_entry.status;
    end

endmodule

[rtl/arp_res_pipe.sv]
`timescale 1ns / 1ps

module arp_res_pipe (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  arp_res_pkg::t_cfg      i_cfg,
    input  logic                   i_in_valid,
    input  arp_res_pkg::t_in_word  i_in_word,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output arp_res_pkg::t_out_word o_out_word,
    input  logic                   i_out_stall
);
    import arp_res_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_entry    r_entry;
    t_entry    n_entry;
    t_out_word n_result;
    logic      w_out_ready;
    logic      w_in_ready;
    logic      w_fire;

    // each stage moves when the one after it has room
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_in_ready  = !r_in_valid || w_out_ready;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_in_stall  = !w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    arp_res_eval u_eval (
        .i_word   (r_in_word),
        .i_entry  (r_entry),
        .i_cfg    (i_cfg),
        .o_entry  (n_entry),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_word <= n_result;
        end
    end

    // cache entry, updated once per word in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.status    <= ST_FREE;
            r_entry.ip        <= 32'd0;
            r_entry.mac       <= 48'd0;
            r_entry.countdown <= 16'd0;
            r_entry.retries   <= 8'd0;
        end else if (w_fire) begin
            r_entry <= n_entry;
        end
    end

    // entry only moves when a word is processed
    a_entry_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_entry))
        else $error("entry changed with no word processed");

    // a word waiting in the input register is kept while the result is stalled
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_ready |=> r_in_valid && $stable(r_in_word))
        else $error("input word lost under stall");

    // a reply or a hit always leaves a valid entry
    a_valid_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.action == ACT_REPLY || r_out_word.action == ACT_HIT)
        |-> r_out_word.entry_status == ST_VALID)
        else $error("reply or hit without valid entry");

    // no action carries no addresses
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.action == ACT_NONE
        |-> r_out_word.peer_mac == 48'd0 && r_out_word.peer_ip == 32'd0)
        else $error("addresses on an empty result");

endmodule

[rtl/arp_entry_resolver.sv]
`timescale 1ns / 1ps

// single-entry arp cache
// input channel: i_in_valid / o_in_stall with i_in_word; mode selects a received
//   arp packet, a timer tick or a resolve query
// output channel: o_out_valid / i_out_stall with o_out_word; every input word
//   gives exactly one result word (action, peer mac, peer ip, entry status)
// a word accepted into the input register is evaluated against the cache
//   entry and lands in the result register once that register has room
// throughput: one word per cycle while the result is not stalled, set by the
//   single evaluation stage between the input register and the result register
// a stalled result is held while the input register still takes one more word;
//   with both registers full, o_in_stall rises until the receiver takes the result
// configuration: apb registers local_ip (0x0), valid_timeout (0x4), pending_timeout
//   (0x8), max_retries (0xc); to be written only while idle by the user, unenforced
// reset: synchronous, active low; both registers empty, entry free, registers
//   back to their defaults

module arp_entry_resolver (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    input  arp_res_pkg::t_in_word  i_in_word,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output arp_res_pkg::t_out_word o_out_word,
    input  logic                   i_out_stall
);
    import arp_res_pkg::*;

    t_cfg w_cfg;

    // configuration registers
    arp_res_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // word pipeline and cache entry
    arp_res_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule
